// ===== hw/rtl/calsec_pkg.sv =====
// calsec_pkg: shared types, constants and the month length table for the
// calendar/seconds converter. No dependencies.

package calsec_pkg;

    localparam int unsigned SEC_W  = 32;
    localparam int unsigned DVR_W  = 7;

    localparam logic [DVR_W-1:0] YEAR_WRAP   = 7'd100;
    localparam logic [DVR_W-1:0] SEC_PER_MIN = 7'd60;
    localparam logic [DVR_W-1:0] MIN_PER_HR  = 7'd60;
    localparam logic [DVR_W-1:0] HR_PER_DAY  = 7'd24;
    localparam logic [DVR_W-1:0] DAY_PER_WK  = 7'd7;

    localparam logic [8:0] DAYS_YEAR = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;
    localparam logic [3:0] LAST_MON  = 4'd12;

    // weekday of the epoch day offset so that (days + 4) % 7 + 1 gives 1 = monday
    localparam logic [SEC_W-1:0] WEEK_OFS = 32'd4;

    localparam logic KIND_TO_SEC  = 1'b0;
    localparam logic KIND_TO_DATE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] total_seconds;
    } t_cs_in;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [7:0]  year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [2:0]  weekday_out;
    } t_cs_out;

    typedef struct packed {
        logic             start;
        logic [SEC_W-1:0] dividend;
        logic [DVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SEC_W-1:0] quot;
        logic [DVR_W-1:0] rem;
    } t_div_rsp;

    // days in month by zero-based index; indexes past december count zero days
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
            4'd1:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/calsec_div.sv =====
// calsec_div: divide by one of the small calendar constants through a rounded-up
// reciprocal multiply, one request at a time. Depends on calsec_pkg.

module calsec_div
    import calsec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned MAG_W  = SEC_W + 1;
    localparam int unsigned PROD_W = SEC_W + MAG_W;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_SHIFT,
        P_REM
    } t_phase;

    t_phase              r_phase;
    logic                r_done;
    logic [SEC_W-1:0]    r_x;
    logic [DVR_W-1:0]    r_div;
    logic [MAG_W-1:0]    r_mag;
    logic [5:0]          r_shift;
    logic [PROD_W-1:0]   r_prod;
    logic [SEC_W-1:0]    r_quot;
    logic [DVR_W-1:0]    r_rem;

    logic [MAG_W-1:0]    w_mag;
    logic [5:0]          w_shift;

    // ceil(2^k / d) with k picked so the quotient is exact for any 32-bit dividend
    always_comb begin
        case (i_req.divisor)
            YEAR_WRAP: begin
                w_mag   = 33'h0_A3D7_0A3E;
                w_shift = 6'd38;
            end
            SEC_PER_MIN: begin
                w_mag   = 33'h0_8888_8889;
                w_shift = 6'd37;
            end
            HR_PER_DAY: begin
                w_mag   = 33'h0_AAAA_AAAB;
                w_shift = 6'd36;
            end
            DAY_PER_WK: begin
                w_mag   = 33'h1_2492_4925;
                w_shift = 6'd35;
            end
            default: begin
                w_mag   = '0;
                w_shift = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == P_REM);
            case (r_phase)
                P_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= i_req.dividend;
                        r_div   <= i_req.divisor;
                        r_mag   <= w_mag;
                        r_shift <= w_shift;
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_prod  <= PROD_W'(r_x) * PROD_W'(r_mag);
                    r_phase <= P_SHIFT;
                end
                P_SHIFT: begin
                    r_quot  <= SEC_W'(r_prod >> r_shift);
                    r_phase <= P_REM;
                end
                P_REM: begin
                    r_rem   <= DVR_W'(r_x - r_quot * SEC_W'(r_div));
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_phase == P_IDLE))
        else $error("divider started while busy");

    a_done_after_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_phase == P_REM))
        else $error("divider done without a run");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/calendar_seconds_converter_top.sv =====
// calendar_seconds_converter_top: sequencer for date/time <-> epoch-2000 seconds.
// Depends on calsec_pkg and calsec_div.

// One beat is converted at a time; o_in_stall stays high from acceptance until
// the result is loaded into the output register, which can still hold the
// previous result when the next beat comes in. Each divide runs on the shared
// reciprocal-multiply unit. Date to seconds runs the year wrap on the divider,
// then adds one year length per elapsed year and one month length per full
// month on the shared adder, then runs the day step, three multiply-add steps
// and the load. Seconds to date takes four divides (by 60, 60, 24 and 7), then
// subtracts one year length per elapsed year and one month length per full
// month, then loads the result.
// The block takes the next beat in the cycle after the load; the load itself
// waits while the output register holds a beat that has not been taken.

module calendar_seconds_converter_top
    import calsec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_cs_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_cs_out o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_YMOD,
        S_YEARS,
        S_MONTHS,
        S_DAY,
        S_MUL_HR,
        S_MUL_MIN,
        S_MUL_SEC,
        S_DIV_S,
        S_DIV_M,
        S_DIV_H,
        S_DIV_W,
        S_YSTEP,
        S_MSTEP,
        S_FIN
    } t_state;

    t_state           r_state;
    t_cs_in           r_in;
    logic [SEC_W-1:0] r_acc;
    logic [7:0]       r_cnt;
    logic [6:0]       r_yoff;
    logic [3:0]       r_mon;
    logic [5:0]       r_sec;
    logic [5:0]       r_min;
    logic [4:0]       r_hr;
    logic [2:0]       r_wd;
    logic             r_out_valid;
    t_cs_out          r_out;
    t_cs_out          n_out;

    t_div_req         w_req;
    t_div_rsp         w_rsp;
    logic             w_accept;
    logic             w_load;
    logic [3:0]       w_full;
    logic [8:0]       w_ylen;
    logic [4:0]       w_mlen;
    logic             w_leap;

    calsec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_full   = (r_in.month == 4'd0) ? 4'd0 : r_in.month - 4'd1;
    // leap on year offset for date->seconds, on running year for seconds->date
    assign w_leap   = (r_in.kind == KIND_TO_SEC) ? (r_yoff[1:0] == 2'd0)
                                                 : (r_cnt[1:0] == 2'd0);
    assign w_ylen   = w_leap ? DAYS_LEAP : DAYS_YEAR;
    assign w_mlen   = month_len(w_leap, r_mon);

    // divider launches from the state that precedes each wait
    always_comb begin
        w_req = '0;
        if (w_accept) begin
            w_req.start = 1'b1;
            if (i_in_data.kind == KIND_TO_SEC) begin
                w_req.dividend = {18'd0, i_in_data.year};
                w_req.divisor  = YEAR_WRAP;
            end else begin
                w_req.dividend = i_in_data.total_seconds;
                w_req.divisor  = SEC_PER_MIN;
            end
        end else if (w_rsp.done) begin
            case (r_state)
                S_DIV_S: begin
                    w_req.start    = 1'b1;
                    w_req.dividend = w_rsp.quot;
                    w_req.divisor  = MIN_PER_HR;
                end
                S_DIV_M: begin
                    w_req.start    = 1'b1;
                    w_req.dividend = w_rsp.quot;
                    w_req.divisor  = HR_PER_DAY;
                end
                S_DIV_H: begin
                    w_req.start    = 1'b1;
                    w_req.dividend = w_rsp.quot + 32'd1 + WEEK_OFS;
                    w_req.divisor  = DAY_PER_WK;
                end
                default: w_req = '0;
            endcase
        end
    end

    always_comb begin
        n_out = '0;
        if (r_in.kind == KIND_TO_SEC) begin
            n_out.seconds_out = r_acc;
        end else begin
            n_out.year_out    = r_cnt;
            n_out.month_out   = r_mon + 4'd1;
            n_out.day_out     = r_acc[4:0];
            n_out.hour_out    = r_hr;
            n_out.minute_out  = r_min;
            n_out.second_out  = r_sec;
            n_out.weekday_out = r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in    <= i_in_data;
                        r_state <= (i_in_data.kind == KIND_TO_SEC) ? S_YMOD : S_DIV_S;
                    end
                end
                S_YMOD: begin
                    if (w_rsp.done) begin
                        r_yoff  <= w_rsp.rem;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= S_YEARS;
                    end
                end
                S_YEARS: begin
                    // one year length per cycle; leap when the count is a multiple of four
                    if (r_cnt == {1'b0, r_yoff}) begin
                        r_mon   <= '0;
                        r_state <= S_MONTHS;
                    end else begin
                        r_acc <= r_acc + (r_cnt[1:0] == 2'd0 ? 32'(DAYS_LEAP)
                                                             : 32'(DAYS_YEAR));
                        r_cnt <= r_cnt + 8'd1;
                    end
                end
                S_MONTHS: begin
                    if (r_mon == w_full) begin
                        r_state <= S_DAY;
                    end else begin
                        r_acc <= r_acc + 32'(w_mlen);
                        r_mon <= r_mon + 4'd1;
                    end
                end
                S_DAY: begin
                    // day zero wraps below the epoch on purpose
                    r_acc   <= r_acc + 32'(r_in.day) - 32'd1;
                    r_state <= S_MUL_HR;
                end
                S_MUL_HR: begin
                    r_acc   <= r_acc * 32'd24 + 32'(r_in.hour);
                    r_state <= S_MUL_MIN;
                end
                S_MUL_MIN: begin
                    r_acc   <= r_acc * 32'd60 + 32'(r_in.minute);
                    r_state <= S_MUL_SEC;
                end
                S_MUL_SEC: begin
                    r_acc   <= r_acc * 32'd60 + 32'(r_in.second);
                    r_state <= S_FIN;
                end
                S_DIV_S: begin
                    if (w_rsp.done) begin
                        r_sec   <= w_rsp.rem[5:0];
                        r_state <= S_DIV_M;
                    end
                end
                S_DIV_M: begin
                    if (w_rsp.done) begin
                        r_min   <= w_rsp.rem[5:0];
                        r_state <= S_DIV_H;
                    end
                end
                S_DIV_H: begin
                    if (w_rsp.done) begin
                        r_hr    <= w_rsp.rem[4:0];
                        r_acc   <= w_rsp.quot + 32'd1;
                        r_state <= S_DIV_W;
                    end
                end
                S_DIV_W: begin
                    if (w_rsp.done) begin
                        r_wd    <= w_rsp.rem[2:0] + 3'd1;
                        r_cnt   <= '0;
                        r_state <= S_YSTEP;
                    end
                end
                S_YSTEP: begin
                    if (r_acc > 32'(w_ylen)) begin
                        r_acc <= r_acc - 32'(w_ylen);
                        r_cnt <= r_cnt + 8'd1;
                    end else begin
                        r_mon   <= 4'd0;
                        r_state <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    // r_mon holds the zero-based month index here
                    if ((r_mon < LAST_MON - 4'd1) && (r_acc > 32'(w_mlen))) begin
                        r_acc <= r_acc - 32'(w_mlen);
                        r_mon <= r_mon + 4'd1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat accepted but converter not busy next cycle");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside the finish step");

    a_div_wait_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_YMOD || r_state == S_DIV_S || r_state == S_DIV_M ||
                        r_state == S_DIV_H || r_state == S_DIV_W))
        else $error("divider finished with no step waiting on it");

endmodule
